// File: rtl/mwrrq_pkg.sv
// Shared types, codes and constants for the multi-writer round-robin queue.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package mwrrq_pkg;

	localparam int WRITERS_DEF = 4;
	localparam int SLOTS_DEF   = 16;

	localparam int BUDGET_W    = 24;
	localparam int JOB_BYTES_W = 19;
	localparam int BIND_SHIFT  = 3;	// Each bind value is one double of eight bytes.

	localparam logic [BUDGET_W-1:0] BUDGET_RESET = 24'd1048576;

	localparam int IN_TDATA_W  = 128;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 152;
	localparam int OUT_TUSER_W = 4;

	localparam logic [1:0] KIND_ENQ  = 2'd0;
	localparam logic [1:0] KIND_DEQ  = 2'd1;
	localparam logic [1:0] KIND_STOP = 2'd2;

	localparam logic [2:0] STATUS_DONE          = 3'd0;
	localparam logic [2:0] STATUS_BAD_ARGS      = 3'd1;
	localparam logic [2:0] STATUS_STOPPING      = 3'd2;
	localparam logic [2:0] STATUS_RING_FULL     = 3'd3;
	localparam logic [2:0] STATUS_OVER_BUDGET   = 3'd4;
	localparam logic [2:0] STATUS_EMPTY         = 3'd5;
	localparam logic [2:0] STATUS_STOPPED_EMPTY = 3'd6;

	localparam logic [7:0] LETTER_A = 8'h41;
	localparam logic [7:0] LETTER_Z = 8'h5A;

	typedef struct packed {
		logic capture;
		logic exec;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic deq_hit;
	} dp_stat_t;

	function automatic logic [JOB_BYTES_W-1:0] job_bytes(input logic jk, input logic [15:0] len);
		logic [JOB_BYTES_W-1:0] wide;
		wide = JOB_BYTES_W'(len);
		job_bytes = jk ? (wide << BIND_SHIFT) : (wide + 1'b1);
	endfunction

endpackage

// File: rtl/mwrrq_ctrl.sv
// Controller state machine of the multi-writer round-robin queue.
// Sequences capture, execute and memory read-out; drives the handshakes.
// Depends on mwrrq_pkg.
module mwrrq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  mwrrq_pkg::dp_stat_t stat,
	output mwrrq_pkg::dp_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	always_comb begin
		s_tready    = (state_q == ST_IDLE);
		out_free    = !out_valid_q || m_tready;
		cmd.capture = s_tready && s_tvalid;
		cmd.exec    = (state_q == ST_EXEC) && out_free;
		cmd.finish  = (state_q == ST_READ);
	end

	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.capture) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (out_free) state_q <= stat.deq_hit ? ST_READ : ST_IDLE;
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// A dequeue that finds a job leaves the output register empty until
			// the memory data is back.
			if ((cmd.exec && !stat.deq_hit) || cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/mwrrq_dp.sv
// Datapath of the multi-writer round-robin queue: descriptor memory, ring
// pointers, round-robin search, byte budget and the output register.
// Depends on mwrrq_pkg.
module mwrrq_dp #(
	parameter int WRITERS = mwrrq_pkg::WRITERS_DEF,
	parameter int SLOTS   = mwrrq_pkg::SLOTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mwrrq_pkg::dp_cmd_t                   cmd,
	output mwrrq_pkg::dp_stat_t                  stat,
	input  logic [mwrrq_pkg::IN_TDATA_W-1:0]     in_tdata,
	input  logic [mwrrq_pkg::IN_TUSER_W-1:0]     in_tuser,
	input  logic                                 cfg_valid,
	input  logic [mwrrq_pkg::BUDGET_W-1:0]       cfg_data,
	output logic [mwrrq_pkg::OUT_TDATA_W-1:0]    out_tdata,
	output logic [mwrrq_pkg::OUT_TUSER_W-1:0]    out_tuser
);

	localparam int WW        = $clog2(WRITERS);
	localparam int SW        = $clog2(SLOTS);
	localparam int AW        = WW + SW;
	localparam int MEM_DEPTH = WRITERS << SW;
	localparam int BW        = mwrrq_pkg::BUDGET_W;
	localparam int JBW       = mwrrq_pkg::JOB_BYTES_W;

	typedef struct packed {
		logic [63:0] seq;
		logic        kind;
		logic [7:0]  letter;
		logic [15:0] length;
		logic [31:0] handle;
	} entry_t;

	function automatic logic [SW-1:0] ring_next(input logic [SW-1:0] p);
		ring_next = (p == SW'(SLOTS - 1)) ? '0 : p + 1'b1;
	endfunction

	// Captured request
	logic [1:0]  kind_q;
	logic [2:0]  writer_q;
	logic        jkind_q;
	logic [63:0] seq_q;
	logic [7:0]  letter_q;
	logic [15:0] len_q;
	logic [31:0] handle_q;

	// Queue state
	logic [BW-1:0] budget_q;
	logic [BW-1:0] total_q;
	logic [SW-1:0] head_q [WRITERS];
	logic [SW-1:0] tail_q [WRITERS];
	logic [WW-1:0] robin_q;
	logic [WW-1:0] chan_q;
	logic          stopping_q;

	entry_t mem_q [MEM_DEPTH];
	entry_t rd_q;

	logic [WRITERS-1:0] nonempty;
	logic               found;
	logic [WW-1:0]      found_ch;
	logic [WW-1:0]      robin_next;
	logic [WW:0]        robin_inc;
	logic               is_deq;
	logic [WW-1:0]      ch;
	logic [SW-1:0]      head_sel;
	logic [SW-1:0]      tail_sel;
	logic [SW-1:0]      head_next;
	logic [SW-1:0]      tail_next;
	logic               writer_ok;
	logic               letter_ok;
	logic [JBW-1:0]     enq_bytes;
	logic [BW:0]        enq_sum;
	logic               over;
	logic               ring_full;
	logic               enq_ok;
	logic [2:0]         op_status;
	logic               mem_we;
	logic               mem_re;
	logic [AW-1:0]      waddr;
	logic [AW-1:0]      raddr;
	entry_t             wentry;
	logic [JBW-1:0]     rd_bytes;
	logic [BW-1:0]      deq_total;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q   <= in_tuser[1:0];
			writer_q <= in_tdata[2:0];
			jkind_q  <= in_tdata[3];
			seq_q    <= in_tdata[67:4];
			letter_q <= in_tdata[75:68];
			len_q    <= in_tdata[91:76];
			handle_q <= in_tdata[123:92];
		end
	end

	always_comb begin
		for (int i = 0; i < WRITERS; i++) begin
			nonempty[i] = (head_q[i] != tail_q[i]);
		end
	end

	// First non-empty channel at or after the round-robin pointer.
	always_comb begin
		logic [WW:0] cand_sum;
		logic [WW-1:0] cand;
		found    = 1'b0;
		found_ch = '0;
		for (int i = 0; i < WRITERS; i++) begin
			cand_sum = {1'b0, robin_q} + (WW + 1)'(i);
			if (cand_sum >= (WW + 1)'(WRITERS)) cand_sum = cand_sum - (WW + 1)'(WRITERS);
			cand = cand_sum[WW-1:0];
			if (!found && nonempty[cand]) begin
				found    = 1'b1;
				found_ch = cand;
			end
		end
		robin_inc  = {1'b0, found_ch} + 1'b1;
		robin_next = (robin_inc >= (WW + 1)'(WRITERS)) ? '0 : robin_inc[WW-1:0];
	end

	always_comb begin
		is_deq    = (kind_q == mwrrq_pkg::KIND_DEQ);
		ch        = is_deq ? found_ch : writer_q[WW-1:0];
		head_sel  = head_q[ch];
		tail_sel  = tail_q[ch];
		head_next = ring_next(head_sel);
		tail_next = ring_next(tail_sel);
		writer_ok = ({1'b0, writer_q} < 4'(WRITERS));
		letter_ok = !jkind_q || (letter_q >= mwrrq_pkg::LETTER_A
			&& letter_q <= mwrrq_pkg::LETTER_Z);
		enq_bytes = mwrrq_pkg::job_bytes(jkind_q, len_q);
		enq_sum   = {1'b0, total_q} + (BW + 1)'(enq_bytes);
		over      = (enq_sum > {1'b0, budget_q});
		ring_full = (head_next == tail_sel);
		stat.deq_hit = is_deq && found;
	end

	always_comb begin
		enq_ok    = 1'b0;
		op_status = mwrrq_pkg::STATUS_BAD_ARGS;
		case (kind_q)
			mwrrq_pkg::KIND_ENQ: begin
				if (!writer_ok || !letter_ok) begin
					op_status = mwrrq_pkg::STATUS_BAD_ARGS;
				end else if (stopping_q) begin
					op_status = mwrrq_pkg::STATUS_STOPPING;
				end else if (ring_full) begin
					op_status = mwrrq_pkg::STATUS_RING_FULL;
				end else if (over) begin
					op_status = mwrrq_pkg::STATUS_OVER_BUDGET;
				end else begin
					op_status = mwrrq_pkg::STATUS_DONE;
					enq_ok    = 1'b1;
				end
			end
			mwrrq_pkg::KIND_DEQ: begin
				op_status = stopping_q ? mwrrq_pkg::STATUS_STOPPED_EMPTY
					: mwrrq_pkg::STATUS_EMPTY;
			end
			mwrrq_pkg::KIND_STOP: begin
				op_status = mwrrq_pkg::STATUS_DONE;
			end
			default: begin
				op_status = mwrrq_pkg::STATUS_BAD_ARGS;
			end
		endcase
	end

	always_comb begin
		mem_we        = cmd.exec && enq_ok;
		mem_re        = cmd.exec && stat.deq_hit;
		waddr         = {writer_q[WW-1:0], head_sel};
		raddr         = {found_ch, tail_sel};
		wentry.seq    = seq_q;
		wentry.kind   = jkind_q;
		wentry.letter = jkind_q ? letter_q : 8'd0;
		wentry.length = len_q;
		wentry.handle = handle_q;
		rd_bytes      = mwrrq_pkg::job_bytes(rd_q.kind, rd_q.length);
		deq_total     = (total_q >= BW'(rd_bytes)) ? total_q - BW'(rd_bytes) : '0;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[waddr] <= wentry;
		if (mem_re) rd_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q   <= mwrrq_pkg::BUDGET_RESET;
			total_q    <= '0;
			robin_q    <= '0;
			chan_q     <= '0;
			stopping_q <= 1'b0;
			for (int i = 0; i < WRITERS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) budget_q <= cfg_data;
			if (cmd.exec) begin
				case (kind_q)
					mwrrq_pkg::KIND_ENQ: begin
						if (enq_ok) begin
							head_q[ch] <= head_next;
							total_q    <= enq_sum[BW-1:0];
						end
					end
					mwrrq_pkg::KIND_DEQ: begin
						if (found) begin
							tail_q[ch] <= tail_next;
							robin_q    <= robin_next;
							chan_q     <= found_ch;
						end
					end
					mwrrq_pkg::KIND_STOP: begin
						stopping_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			if (cmd.finish) total_q <= deq_total;
		end
	end

	// Result register. Results without a job carry zeros in the job fields.
	always_ff @(posedge clk) begin
		if (cmd.exec && !stat.deq_hit) begin
			out_tuser <= {1'b0, op_status};
			out_tdata <= {4'd0, (enq_ok ? enq_sum[BW-1:0] : total_q), 124'd0};
		end else if (cmd.finish) begin
			out_tuser <= {1'b1, mwrrq_pkg::STATUS_DONE};
			out_tdata <= {4'd0, deq_total, rd_q.handle, rd_q.length, rd_q.letter,
				rd_q.seq, 3'(chan_q), rd_q.kind};
		end
	end

endmodule

// File: rtl/multi_writer_round_robin_queue_unit.sv
// Top level of the multi-writer round-robin job queue.
// Instantiates mwrrq_ctrl and mwrrq_dp; depends on mwrrq_pkg.
//
// Usage:
//   The request stream (s_t*) carries one operation per item: tuser selects
//   enqueue, dequeue or stop; tdata carries the job descriptor for enqueue.
//   The result stream (m_t*) returns exactly one item per request: tuser
//   holds the status and the job-valid flag, tdata the dequeued job and the
//   byte count queued after the operation.
//   The cfg channel writes the byte budget and is always ready; the user must
//   write it only while the block is idle, which the block does not enforce.
// Sequencing:
//   A request is captured while the block is idle and executed in the execute
//   state once the output register is free; its result is registered in the
//   output register. A new item is accepted only after the last one is through.
//   A dequeue that finds a job goes through a further state for the registered
//   read of the descriptor memory before the next item is accepted.
// Reset:
//   All rings are empty, the round-robin pointer is at channel 0, nothing is
//   queued, the bus is running and the budget is 1048576 bytes. The memory is
//   not cleared; an entry is only read after it has been written.
// Stalls:
//   A finished result waits in the output register; the next item is still
//   accepted, and its execution waits until the output register is free.
module multi_writer_round_robin_queue_unit #(
	parameter int WRITERS = mwrrq_pkg::WRITERS_DEF,
	parameter int SLOTS   = mwrrq_pkg::SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// writer[2:0], job_kind[3], sequence_req[67:4], letter[75:68],
	// length[91:76], payload_handle[123:92], zero fill above
	input  logic [mwrrq_pkg::IN_TDATA_W-1:0]  s_tdata,
	// kind[1:0]
	input  logic [mwrrq_pkg::IN_TUSER_W-1:0]  s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// job_kind_out[0], writer_out[3:1], sequence_out[67:4], letter_out[75:68],
	// length_out[91:76], payload_out[123:92], bytes_queued[147:124], zero fill
	output logic [mwrrq_pkg::OUT_TDATA_W-1:0] m_tdata,
	// status[2:0], job_valid[3]
	output logic [mwrrq_pkg::OUT_TUSER_W-1:0] m_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mwrrq_pkg::BUDGET_W-1:0]    cfg_data
);

	mwrrq_pkg::dp_cmd_t  cmd;
	mwrrq_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	mwrrq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mwrrq_dp #(
		.WRITERS (WRITERS),
		.SLOTS   (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_tdata  (s_tdata),
		.in_tuser  (s_tuser),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.out_tdata (m_tdata),
		.out_tuser (m_tuser)
	);

endmodule

// File: rtl/mwrrq_checker.sv
// Port-level checks for the multi-writer round-robin queue, bound to the
// top level. Depends on mwrrq_pkg and multi_writer_round_robin_queue_unit.
module mwrrq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [mwrrq_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [mwrrq_pkg::OUT_TUSER_W-1:0] m_tuser
);

	// A result that carries a job always reports success.
	a_job_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3] |-> m_tuser[2:0] == mwrrq_pkg::STATUS_DONE)
		else $error("job presented with a failing status");

	// Results without a job have all job fields cleared.
	a_no_job_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[3] |-> m_tdata[123:0] == '0)
		else $error("job fields not zero without a job");

	// One item is worked on at a time: an accepted item closes the input.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted while one is in work");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind multi_writer_round_robin_queue_unit mwrrq_checker u_mwrrq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
